[rtl/core/bth_pkg.sv]
// Types and constants shared by the BER/DER TLV header decoder.
package bth_pkg;

  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_TAGLONG = 2'd1,
    PH_LENHEAD = 2'd2,
    PH_LENLONG = 2'd3
  } phase_t;

  typedef enum logic [3:0] {
    ST_OK        = 4'd0,
    ST_EOF_TAG   = 4'd1,
    ST_SHORT_TAG = 4'd2,
    ST_TAG_OVF   = 4'd3,
    ST_EOF_LEN   = 4'd4,
    ST_RESERVED  = 4'd5,
    ST_INDEF     = 4'd6,
    ST_NONMIN    = 4'd7,
    ST_LEN_OVF   = 4'd8
  } status_t;

  localparam logic [4:0]  TAG_LONG_MARK  = 5'h1F;
  localparam logic [6:0]  LEN_FORM_RSVD  = 7'h7F;
  localparam logic [31:0] TAG_SHORT_MAX  = 32'd30;
  localparam logic [31:0] LEN_SHORT_MAX  = 32'h0000_007F;
  localparam logic        DER_MODE_RESET = 1'b1;

endpackage

[rtl/core/ber_tlv_header_decoder.sv]
// ASN.1 BER/DER identifier and length header decoder, one byte per transaction.
// Pipeline: a byte is registered on acceptance and parsed from that stage register;
//   its result, if any, is registered into the result register when the parse fires.
// Throughput: one byte per cycle unless a result waits on out_ready; header state updates once per byte.
// Reset (rst_n low, synchronous): parser idle, pipeline and result register empty,
//   der_mode set to 1.
module ber_tlv_header_decoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_start_req,
  input  logic        in_last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_tag_class,
  output logic [31:0] out_tag_number,
  output logic [31:0] out_content_length,
  output logic [3:0]  out_status
);

  logic             der_mode_r;
  logic             s1_valid_r;
  logic [7:0]       s1_byte_r;
  logic             s1_start_r;
  logic             s1_last_r;
  bth_pkg::phase_t  phase_r, phase_nxt;
  logic [2:0]       class_r, class_nxt;
  logic [31:0]      tag_r, tag_nxt;
  logic [31:0]      len_r, len_nxt;
  logic [6:0]       left_r, left_nxt;
  logic             emit;
  bth_pkg::status_t status;
  logic [31:0]      tag_sh;
  logic [31:0]      len_sh;
  logic [6:0]       left_dec;
  logic             s1_go;
  logic             s1_fire;
  logic             out_valid_r;
  logic [2:0]       res_class_nxt, res_class_r;
  logic [31:0]      res_tag_nxt, res_tag_r;
  logic [31:0]      res_len_nxt, res_len_r;
  logic [3:0]       res_status_nxt, res_status_r;

  assign s1_go    = !emit || !out_valid_r || out_ready;
  assign s1_fire  = s1_valid_r && s1_go;
  assign in_ready = !s1_valid_r || s1_go;

  assign tag_sh   = {tag_r[24:0], s1_byte_r[6:0]};
  assign len_sh   = {len_r[23:0], s1_byte_r};
  assign left_dec = left_r - 7'd1;

  // next state of the header parser
  always_comb begin
    phase_nxt = phase_r;
    class_nxt = class_r;
    tag_nxt   = tag_r;
    len_nxt   = len_r;
    left_nxt  = left_r;
    emit      = 1'b0;
    status    = bth_pkg::ST_OK;
    if (s1_start_r) begin
      class_nxt = s1_byte_r[7:5];
      len_nxt   = '0;
      left_nxt  = '0;
      if (s1_byte_r[4:0] != bth_pkg::TAG_LONG_MARK) begin
        tag_nxt   = {27'd0, s1_byte_r[4:0]};
        phase_nxt = bth_pkg::PH_LENHEAD;
        if (s1_last_r) begin
          emit   = 1'b1;
          status = bth_pkg::ST_EOF_LEN;
        end
      end else begin
        tag_nxt   = '0;
        phase_nxt = bth_pkg::PH_TAGLONG;
        if (s1_last_r) begin
          emit   = 1'b1;
          status = bth_pkg::ST_EOF_TAG;
        end
      end
    end else begin
      case (phase_r)
        bth_pkg::PH_TAGLONG: begin
          if (|tag_r[31:25]) begin
            emit   = 1'b1;
            status = bth_pkg::ST_TAG_OVF;
          end else begin
            tag_nxt = tag_sh;
            if (s1_byte_r[7]) begin
              if (s1_last_r) begin
                emit   = 1'b1;
                status = bth_pkg::ST_EOF_TAG;
              end
            end else if (tag_sh <= bth_pkg::TAG_SHORT_MAX) begin
              emit   = 1'b1;
              status = bth_pkg::ST_SHORT_TAG;
            end else begin
              phase_nxt = bth_pkg::PH_LENHEAD;
              if (s1_last_r) begin
                emit   = 1'b1;
                status = bth_pkg::ST_EOF_LEN;
              end
            end
          end
        end
        bth_pkg::PH_LENHEAD: begin
          if (!s1_byte_r[7]) begin
            len_nxt = {24'd0, s1_byte_r};
            emit    = 1'b1;
            status  = bth_pkg::ST_OK;
          end else if (s1_byte_r[6:0] == bth_pkg::LEN_FORM_RSVD) begin
            emit   = 1'b1;
            status = bth_pkg::ST_RESERVED;
          end else if (s1_byte_r[6:0] == 7'd0) begin
            emit   = 1'b1;
            status = bth_pkg::ST_INDEF;
          end else begin
            len_nxt   = '0;
            left_nxt  = s1_byte_r[6:0];
            phase_nxt = bth_pkg::PH_LENLONG;
            if (s1_last_r) begin
              emit   = 1'b1;
              status = bth_pkg::ST_EOF_LEN;
            end
          end
        end
        bth_pkg::PH_LENLONG: begin
          // DER forbids a leading zero length byte
          if (der_mode_r && s1_byte_r == 8'd0 && len_r == 32'd0 && left_r != 7'd1) begin
            emit   = 1'b1;
            status = bth_pkg::ST_NONMIN;
          end else if (|len_r[31:24]) begin
            emit   = 1'b1;
            status = bth_pkg::ST_LEN_OVF;
          end else begin
            len_nxt  = len_sh;
            left_nxt = left_dec;
            if (left_dec == 7'd0) begin
              emit   = 1'b1;
              status = (der_mode_r && len_sh <= bth_pkg::LEN_SHORT_MAX) ?
                       bth_pkg::ST_NONMIN : bth_pkg::ST_OK;
            end else if (s1_last_r) begin
              emit   = 1'b1;
              status = bth_pkg::ST_EOF_LEN;
            end
          end
        end
        default: begin
          phase_nxt = bth_pkg::PH_IDLE;
        end
      endcase
    end
    if (emit) begin
      phase_nxt = bth_pkg::PH_IDLE;
    end
  end

  // result fields; error results carry zeros
  always_comb begin
    res_status_nxt = status;
    if (status == bth_pkg::ST_OK) begin
      res_class_nxt = class_nxt;
      res_tag_nxt   = tag_nxt;
      res_len_nxt   = len_nxt;
    end else begin
      res_class_nxt = '0;
      res_tag_nxt   = '0;
      res_len_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      der_mode_r  <= bth_pkg::DER_MODE_RESET;
      s1_valid_r  <= 1'b0;
      phase_r     <= bth_pkg::PH_IDLE;
      class_r     <= '0;
      tag_r       <= '0;
      len_r       <= '0;
      left_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        der_mode_r <= cfg_wdata;
      end
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (s1_fire) begin
        phase_r <= phase_nxt;
        class_r <= class_nxt;
        tag_r   <= tag_nxt;
        len_r   <= len_nxt;
        left_r  <= left_nxt;
      end
      if (s1_fire && emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_byte_r  <= in_data_byte;
      s1_start_r <= in_start_req;
      s1_last_r  <= in_last;
    end
    if (s1_fire && emit) begin
      res_class_r  <= res_class_nxt;
      res_tag_r    <= res_tag_nxt;
      res_len_r    <= res_len_nxt;
      res_status_r <= res_status_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_tag_class      = res_class_r;
  assign out_tag_number     = res_tag_r;
  assign out_content_length = res_len_r;
  assign out_status         = res_status_r;

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && res_status_r != bth_pkg::ST_OK |->
      res_class_r == 3'd0 && res_tag_r == 32'd0 && res_len_r == 32'd0)
    else $error("error result carries nonzero fields");

  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> res_status_r <= bth_pkg::ST_LEN_OVF)
    else $error("result status out of range");

  a_lenlong_left: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == bth_pkg::PH_LENLONG |-> left_r != 7'd0)
    else $error("long length phase with no length bytes left");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready |=> out_valid_r && $stable(res_tag_r) && $stable(res_len_r))
    else $error("pending result overwritten");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid_r && !s1_valid_r)
    else $error("pipeline not empty after reset");

endmodule
